### sv/ypf_pkg.sv
// Shared types and constants for the YUV pixel fetch and RGB conversion block.
// No dependencies; imported by ypf_addr_gen, ypf_convert and the top level.
package ypf_pkg;

  // Transfer payloads
  typedef struct packed {
    logic       action;
    logic [11:0] byte_address;
    logic [7:0]  byte_value;
    logic [9:0]  column;
    logic [9:0]  row;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] status;
  } out_t;

  // Control group passed along the fetch path
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } fetch_ctl_t;

  // Item actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Pixel layouts
  localparam logic [1:0] FMT_YUYV = 2'd0;
  localparam logic [1:0] FMT_I420 = 2'd1;
  localparam logic [1:0] FMT_UYY  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_FORMAT = 2'd1;
  localparam logic [1:0] STATUS_OUT_RANGE  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

  // Configuration reset values
  localparam logic [1:0]  RST_PIXEL_FORMAT = FMT_YUYV;
  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd64;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd32;

  // Width of the byte address arithmetic; holds 5*h*w for 11-bit sizes
  localparam int CALC_W = 26;

endpackage

### sv/ypf_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module ypf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/ypf_addr_gen.sv
// Two-stage byte address generator for the luma and chroma samples of a pixel.
// Depends on ypf_pkg for layout and status codes.
module ypf_addr_gen import ypf_pkg::*; #(
  parameter int FRAME_BYTES = 4096,
  localparam int AW = $clog2(FRAME_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  logic [1:0]    fmt,
  input  logic [10:0]   width,
  input  logic [10:0]   height,
  input  logic [9:0]    column,
  input  logic [9:0]    row,
  output fetch_ctl_t    ctl,
  output logic [AW-1:0] addr_y,
  output logic [AW-1:0] addr_u,
  output logic [AW-1:0] addr_v
);

  // Stage 1: products and early checks
  logic              s1_valid_r;
  logic [CALC_W-1:0] yw_r;
  logic [CALC_W-1:0] hyw_r;
  logic [CALC_W-1:0] hw_r;
  logic [CALC_W-1:0] w_r;
  logic [9:0]        x_r;
  logic              y0_r;
  logic [1:0]        fmt_r;
  logic              bad_fmt_r;
  logic              oob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req_valid;
    end
    if (req_valid) begin
      yw_r      <= CALC_W'(row) * CALC_W'(width);
      hyw_r     <= CALC_W'(row[9:1]) * CALC_W'(width);
      hw_r      <= CALC_W'(height) * CALC_W'(width);
      w_r       <= CALC_W'(width);
      x_r       <= column;
      y0_r      <= row[0];
      fmt_r     <= fmt;
      bad_fmt_r <= (fmt != FMT_YUYV) && (fmt != FMT_I420) && (fmt != FMT_UYY);
      oob_r     <= ({1'b0, column} >= width) || ({1'b0, row} >= height);
    end
  end

  // Stage 2: layout sums and store range check
  logic [CALC_W-1:0] ay_nxt, au_nxt, av_nxt;
  logic [CALC_W-1:0] base, coff, ubase, vbase, xh;
  logic [1:0]        status_nxt;

  always_comb begin
    xh     = CALC_W'(x_r[9:1]);
    base   = '0;
    coff   = '0;
    ubase  = '0;
    vbase  = '0;
    ay_nxt = '0;
    au_nxt = '0;
    av_nxt = '0;
    unique case (fmt_r)
      FMT_YUYV: begin
        base   = (yw_r << 1) + (xh << 2);
        ay_nxt = base;
        au_nxt = base + CALC_W'(1);
        av_nxt = base + CALC_W'(3);
      end
      FMT_I420: begin
        coff   = (hyw_r >> 1) + xh;
        ay_nxt = yw_r + CALC_W'(x_r);
        au_nxt = hw_r + coff;
        av_nxt = (((hw_r << 2) + hw_r) >> 2) + coff;
      end
      FMT_UYY: begin
        ubase  = (hyw_r << 1) + hyw_r + (xh << 1) + xh;
        vbase  = ubase + (((w_r << 1) + w_r) >> 1);
        au_nxt = ubase;
        av_nxt = vbase;
        ay_nxt = (y0_r ? vbase : ubase) + CALC_W'(1) + CALC_W'(x_r[0]);
      end
      default: begin
        ay_nxt = '0;
      end
    endcase

    // Format first, then coordinate, then store bounds
    if (bad_fmt_r) begin
      status_nxt = STATUS_BAD_FORMAT;
    end else if (oob_r) begin
      status_nxt = STATUS_OUT_RANGE;
    end else if ((ay_nxt >= CALC_W'(FRAME_BYTES)) || (au_nxt >= CALC_W'(FRAME_BYTES)) ||
                 (av_nxt >= CALC_W'(FRAME_BYTES))) begin
      status_nxt = STATUS_OUT_RANGE;
    end else begin
      status_nxt = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= s1_valid_r;
    end
    if (s1_valid_r) begin
      ctl.status <= status_nxt;
      addr_y     <= ay_nxt[AW-1:0];
      addr_u     <= au_nxt[AW-1:0];
      addr_v     <= av_nxt[AW-1:0];
    end
  end

endmodule

### sv/ypf_convert.sv
// Two-stage BT.601 integer YUV to RGB888 converter with clamping.
// Depends on ypf_pkg for the result struct and status codes.
module ypf_convert import ypf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fetch_ctl_t ctl,
  input  logic [7:0] luma,
  input  logic [7:0] cb,
  input  logic [7:0] cr,
  output logic       pix_strobe,
  output out_t       pix
);

  localparam int ACC_W = 20;

  function automatic logic [7:0] clamp8(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = acc >>> 8;
    if (acc < 0) begin
      return 8'd0;
    end else if (sh > ACC_W'(255)) begin
      return 8'd255;
    end else begin
      return sh[7:0];
    end
  endfunction

  // Remove offsets
  logic signed [8:0] c_s, d_s, e_s;

  always_comb begin
    c_s = $signed({1'b0, luma}) - 9'sd16;
    d_s = $signed({1'b0, cb}) - 9'sd128;
    e_s = $signed({1'b0, cr}) - 9'sd128;
  end

  // Stage 1: coefficient products
  logic                    s1_valid_r;
  logic [1:0]              s1_status_r;
  logic signed [ACC_W-1:0] yc_r, re_r, gd_r, ge_r, bd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= ctl.valid;
    end
    if (ctl.valid) begin
      s1_status_r <= ctl.status;
      yc_r        <= ACC_W'(c_s) * 20'sd298;
      re_r        <= ACC_W'(e_s) * 20'sd409;
      gd_r        <= ACC_W'(d_s) * 20'sd100;
      ge_r        <= ACC_W'(e_s) * 20'sd208;
      bd_r        <= ACC_W'(d_s) * 20'sd516;
    end
  end

  // Stage 2: sums, rounding and clamp
  logic signed [ACC_W-1:0] r_acc, g_acc, b_acc;
  out_t                    pix_nxt;

  always_comb begin
    r_acc = yc_r + re_r + 20'sd128;
    g_acc = yc_r - gd_r - ge_r + 20'sd128;
    b_acc = yc_r + bd_r + 20'sd128;
    pix_nxt.status = s1_status_r;
    if (s1_status_r == STATUS_OK) begin
      pix_nxt.red   = clamp8(r_acc);
      pix_nxt.green = clamp8(g_acc);
      pix_nxt.blue  = clamp8(b_acc);
    end else begin
      pix_nxt.red   = 8'd0;
      pix_nxt.green = 8'd0;
      pix_nxt.blue  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_strobe <= 1'b0;
    end else begin
      pix_strobe <= s1_valid_r;
    end
    if (s1_valid_r) begin
      pix <= pix_nxt;
    end
  end

endmodule

### sv/yuv_pixel_fetch_to_rgb_unit.sv
// Top level: frame store, fetch sequencer, address generator and RGB converter.
// Depends on ypf_pkg, ypf_ram, ypf_addr_gen and ypf_convert.
//
//   channel   ports                          transfer
//   --------  -----------------------------  ---------------------------------
//   input     start, busy, in_data           start high while busy low
//   result    out_strobe, out_data           out_strobe high, one cycle
//   config    cfg_we, cfg_index, cfg_data    cfg_we high
//
// A byte write leaves busy low, so writes stream at one per cycle. A pixel read
// holds busy high while the address generator, the three store reads and the
// converter stages run; a read that fails a format or range check skips the
// store reads. The next item is taken in the cycle after the strobe. The single
// frame store port carries the three sample reads in successive cycles. Reset
// clears state, valid flags and config; the store holds garbage until written.
module yuv_pixel_fetch_to_rgb_unit import ypf_pkg::*; #(
  parameter int FRAME_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_strobe,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int AW = $clog2(FRAME_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_RD_U,
    S_RD_V,
    S_CAP_V,
    S_CONV
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  pixel_format_r;
  logic [10:0] frame_width_r;
  logic [10:0] frame_height_r;
  logic [7:0]  luma_r, cb_r;

  logic          accept, read_req, wr_hit;
  fetch_ctl_t    addr_ctl, conv_ctl;
  logic [AW-1:0] addr_y, addr_u, addr_v;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [7:0]    ram_rdata;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign read_req = accept && (in_data.action == ACT_READ);
  assign wr_hit   = CALC_W'(in_data.byte_address) < CALC_W'(FRAME_BYTES);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= RST_PIXEL_FORMAT;
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT: pixel_format_r <= cfg_data[1:0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ypf_addr_gen #(.FRAME_BYTES(FRAME_BYTES)) u_addr_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (read_req),
    .fmt       (pixel_format_r),
    .width     (frame_width_r),
    .height    (frame_height_r),
    .column    (in_data.column),
    .row       (in_data.row),
    .ctl       (addr_ctl),
    .addr_y    (addr_y),
    .addr_u    (addr_u),
    .addr_v    (addr_v)
  );

  // Share the store port between idle writes and the three sample reads
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = AW'(in_data.byte_address);
    case (state_r)
      S_IDLE: begin
        ram_we = accept && (in_data.action == ACT_WRITE) && wr_hit;
      end
      S_ADDR:  ram_addr = addr_y;
      S_RD_U:  ram_addr = addr_u;
      S_RD_V:  ram_addr = addr_v;
      default: ram_addr = AW'(in_data.byte_address);
    endcase
  end

  ypf_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data.byte_value),
    .rdata (ram_rdata)
  );

  // Sequencer next state and converter launch
  always_comb begin
    state_nxt       = state_r;
    conv_ctl.valid  = 1'b0;
    conv_ctl.status = STATUS_OK;
    unique case (state_r)
      S_IDLE: begin
        if (read_req) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        if (addr_ctl.valid) begin
          if (addr_ctl.status != STATUS_OK) begin
            conv_ctl.valid  = 1'b1;
            conv_ctl.status = addr_ctl.status;
            state_nxt       = S_CONV;
          end else begin
            state_nxt = S_RD_U;
          end
        end
      end
      S_RD_U:  state_nxt = S_RD_V;
      S_RD_V:  state_nxt = S_CAP_V;
      S_CAP_V: begin
        conv_ctl.valid = 1'b1;
        state_nxt      = S_CONV;
      end
      S_CONV: begin
        if (out_strobe) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and capture returning samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (state_r == S_RD_U) begin
      luma_r <= ram_rdata;
    end
    if (state_r == S_RD_V) begin
      cb_r <= ram_rdata;
    end
  end

  ypf_convert u_convert (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (conv_ctl),
    .luma       (luma_r),
    .cb         (cb_r),
    .cr         (ram_rdata),
    .pix_strobe (out_strobe),
    .pix        (out_data)
  );

endmodule
